@@ rtl/clcd_pkg.sv @@
// Shared types, codes, constants and lookup functions for the character LCD
// write sequencer. No dependencies; every other file uses this package.
`timescale 1ns / 1ps

package clcd_pkg;

   // Field widths of the request and response words and of the internal counters.
   localparam int OP_W      = 3;
   localparam int BYTE_W    = 8;
   localparam int COLUMN_W  = 4;
   localparam int NUMBER_W  = 16;
   localparam int NIBBLE_W  = 4;
   localparam int LEAD_W    = 15;
   localparam int SETTLE_W  = 13;
   localparam int STEP_W    = 4;
   localparam int PLACE_W   = 3;
   localparam int WEIGHT_W  = 14;

   // Operation codes carried in the request word.
   localparam logic [OP_W-1:0] OP_INIT    = 3'd0;
   localparam logic [OP_W-1:0] OP_COMMAND = 3'd1;
   localparam logic [OP_W-1:0] OP_DATA    = 3'd2;
   localparam logic [OP_W-1:0] OP_CURSOR  = 3'd3;
   localparam logic [OP_W-1:0] OP_PRINT   = 3'd4;

   // Commands that need the long execution wait.
   localparam logic [BYTE_W-1:0] CMD_CLEAR = 8'h01;
   localparam logic [BYTE_W-1:0] CMD_HOME  = 8'h02;

   // Bus timing in microseconds.
   localparam logic [LEAD_W-1:0]   LEAD_NONE    = 15'd0;
   localparam logic [LEAD_W-1:0]   LEAD_POWERUP = 15'd20000;
   localparam logic [SETTLE_W-1:0] SETTLE_US    = 13'd50;
   localparam logic [SETTLE_W-1:0] SETTLE_WAKE  = 13'd200;
   localparam logic [SETTLE_W-1:0] SETTLE_FIRST = 13'd5050;
   localparam logic [SETTLE_W-1:0] SETTLE_SLOW  = 13'd2050;

   // Initialization runs through fourteen nibbles.
   localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd13;

   // Decimal printing walks five places, ten thousands down to units.
   localparam logic [PLACE_W-1:0]  DIGIT_LAST_PLACE  = 3'd4;
   localparam logic [NIBBLE_W-1:0] DIGIT_HIGH_NIBBLE = 4'h3;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_INIT,
      SEQ_HI,
      SEQ_LO,
      SEQ_DIGIT
   } seq_state_type;

   typedef enum logic [1:0] {
      DIG_IDLE,
      DIG_RUN,
      DIG_HOLD
   } dig_state_type;

   typedef struct packed {
      logic                rs_level;
      logic [NIBBLE_W-1:0] data_nibble;
      logic [LEAD_W-1:0]   lead_us;
      logic [SETTLE_W-1:0] settle_us;
      logic                last_of_run;
   } nib_word_type;

   typedef struct packed {
      logic                start;
      logic [NUMBER_W-1:0] number;
      logic                take;
   } digit_cmd_type;

   typedef struct packed {
      logic                valid;
      logic [NIBBLE_W-1:0] value;
      logic                last;
   } digit_out_type;

   // Power-up nibbles 3,3,3,2, then commands 28, 08, 01, 06, 0C as nibble pairs.
   function automatic nib_word_type init_nibble(input logic [STEP_W-1:0] step);
      nib_word_type w;
      w.rs_level    = 1'b0;
      w.lead_us     = LEAD_NONE;
      w.settle_us   = SETTLE_US;
      w.last_of_run = 1'b0;
      w.data_nibble = 4'h0;
      unique case (step)
         4'd0: begin
            w.data_nibble = 4'h3;
            w.lead_us     = LEAD_POWERUP;
            w.settle_us   = SETTLE_FIRST;
         end
         4'd1, 4'd2: begin
            w.data_nibble = 4'h3;
            w.settle_us   = SETTLE_WAKE;
         end
         4'd3: begin
            w.data_nibble = 4'h2;
            w.settle_us   = SETTLE_WAKE;
         end
         4'd4:  w.data_nibble = 4'h2;
         4'd5:  w.data_nibble = 4'h8;
         4'd6:  w.data_nibble = 4'h0;
         4'd7:  w.data_nibble = 4'h8;
         4'd8:  w.data_nibble = 4'h0;
         4'd9: begin
            w.data_nibble = 4'h1;
            w.settle_us   = SETTLE_SLOW;
         end
         4'd10: w.data_nibble = 4'h0;
         4'd11: w.data_nibble = 4'h6;
         4'd12: w.data_nibble = 4'h0;
         4'd13: w.data_nibble = 4'hC;
         default: w.data_nibble = 4'h0;
      endcase
      return w;
   endfunction

   // Weight of a decimal place, place 0 being ten thousands.
   function automatic logic [WEIGHT_W-1:0] place_weight(input logic [PLACE_W-1:0] place);
      logic [WEIGHT_W-1:0] w;
      unique case (place)
         3'd0:    w = 14'd10000;
         3'd1:    w = 14'd1000;
         3'd2:    w = 14'd100;
         3'd3:    w = 14'd10;
         default: w = 14'd1;
      endcase
      return w;
   endfunction

endpackage

@@ rtl/clcd_if.sv @@
// Valid/ready channel interfaces for requests and nibble responses.
// Depends on clcd_pkg for field widths.
`timescale 1ns / 1ps

interface clcd_req_if;
   logic                           valid;
   logic                           ready;
   logic [clcd_pkg::OP_W-1:0]      operation;
   logic [clcd_pkg::BYTE_W-1:0]    byte_value;
   logic                           row;
   logic [clcd_pkg::COLUMN_W-1:0]  column;
   logic [clcd_pkg::NUMBER_W-1:0]  number;

   modport source (output valid, operation, byte_value, row, column, number,
                   input ready);
   modport sink   (input valid, operation, byte_value, row, column, number,
                   output ready);
endinterface

interface clcd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           rs_level;
   logic [clcd_pkg::NIBBLE_W-1:0]  data_nibble;
   logic [clcd_pkg::LEAD_W-1:0]    lead_us;
   logic [clcd_pkg::SETTLE_W-1:0]  settle_us;
   logic                           last_of_run;

   modport source (output valid, rs_level, data_nibble, lead_us, settle_us, last_of_run,
                   input ready);
   modport sink   (input valid, rs_level, data_nibble, lead_us, settle_us, last_of_run,
                   output ready);
endinterface

@@ rtl/clcd_digit_unit.sv @@
// Decimal digit extractor: one shared compare/subtract step per cycle while running; each digit is held until taken.
// Depends on clcd_pkg.
`timescale 1ns / 1ps

module clcd_digit_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  clcd_pkg::digit_cmd_type digit_cmd,
   output clcd_pkg::digit_out_type digit_out
);
   import clcd_pkg::*;

   dig_state_type         state_ff, state_in;
   logic [NUMBER_W-1:0]   rem_ff, rem_in;
   logic [PLACE_W-1:0]    place_ff, place_in;
   logic [NIBBLE_W-1:0]   digit_ff, digit_in;
   logic                  seen_ff, seen_in;

   logic [NUMBER_W-1:0]   weight;
   logic                  fits;
   logic [NUMBER_W-1:0]   diff;

   assign weight = {{(NUMBER_W-WEIGHT_W){1'b0}}, place_weight(place_ff)};
   assign fits   = (rem_ff >= weight);
   assign diff   = rem_ff - weight;

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      place_in = place_ff;
      digit_in = digit_ff;
      seen_in  = seen_ff;
      unique case (state_ff)
         DIG_IDLE: begin
            if (digit_cmd.start) begin
               rem_in   = digit_cmd.number;
               place_in = '0;
               digit_in = '0;
               seen_in  = 1'b0;
               state_in = DIG_RUN;
            end
         end
         DIG_RUN: begin
            if (fits) begin
               rem_in   = diff;
               digit_in = digit_ff + 4'd1;
            end else if (digit_ff != '0 || seen_ff || place_ff == DIGIT_LAST_PLACE) begin
               seen_in  = 1'b1;
               state_in = DIG_HOLD;
            end else begin
               // Leading zero: move to the next place without showing it.
               place_in = place_ff + 3'd1;
            end
         end
         DIG_HOLD: begin
            if (digit_cmd.take) begin
               if (place_ff == DIGIT_LAST_PLACE) begin
                  state_in = DIG_IDLE;
               end else begin
                  place_in = place_ff + 3'd1;
                  digit_in = '0;
                  state_in = DIG_RUN;
               end
            end
         end
         default: state_in = DIG_IDLE;
      endcase
   end

   always_comb begin
      digit_out.valid = (state_ff == DIG_HOLD);
      digit_out.value = digit_ff;
      digit_out.last  = (place_ff == DIGIT_LAST_PLACE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIG_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rem_ff   <= rem_in;
      place_ff <= place_in;
      digit_ff <= digit_in;
      seen_ff  <= seen_in;
   end

endmodule

@@ rtl/clcd_sequencer.sv @@
// Request decoder and nibble sequencer: turns each used request into a run of nibbles.
// Depends on clcd_pkg, clcd_if and the digit unit's handshake.
`timescale 1ns / 1ps

module clcd_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   clcd_req_if.sink                req_bus,
   output clcd_pkg::nib_word_type  emit_word,
   output logic                    emit_valid,
   input  logic                    emit_ready,
   output clcd_pkg::digit_cmd_type digit_cmd,
   input  clcd_pkg::digit_out_type digit_out
);
   import clcd_pkg::*;

   seq_state_type       state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic                rs_ff, rs_in;
   logic                last_ff, last_in;
   logic                print_ff, print_in;

   logic                req_fire;
   logic                slow_cmd;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign slow_cmd = !rs_ff && (byte_ff == CMD_CLEAR || byte_ff == CMD_HOME);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      byte_in  = byte_ff;
      rs_in    = rs_ff;
      last_in  = last_ff;
      print_in = print_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_fire) begin
               step_in  = '0;
               last_in  = 1'b1;
               print_in = 1'b0;
               unique case (req_bus.operation)
                  OP_INIT: state_in = SEQ_INIT;
                  OP_COMMAND: begin
                     rs_in    = 1'b0;
                     byte_in  = req_bus.byte_value;
                     state_in = SEQ_HI;
                  end
                  OP_DATA: begin
                     rs_in    = 1'b1;
                     byte_in  = req_bus.byte_value;
                     state_in = SEQ_HI;
                  end
                  OP_CURSOR: begin
                     rs_in    = 1'b0;
                     byte_in  = {1'b1, req_bus.row, 2'b00, req_bus.column};
                     state_in = SEQ_HI;
                  end
                  OP_PRINT: begin
                     rs_in    = 1'b1;
                     print_in = 1'b1;
                     state_in = SEQ_DIGIT;
                  end
                  default: state_in = SEQ_IDLE;
               endcase
            end
         end
         SEQ_INIT: begin
            if (emit_ready) begin
               if (step_ff == INIT_LAST_STEP) begin
                  state_in = SEQ_IDLE;
               end else begin
                  step_in = step_ff + 4'd1;
               end
            end
         end
         SEQ_HI: begin
            if (emit_ready) begin
               state_in = SEQ_LO;
            end
         end
         SEQ_LO: begin
            if (emit_ready) begin
               state_in = (print_ff && !last_ff) ? SEQ_DIGIT : SEQ_IDLE;
            end
         end
         SEQ_DIGIT: begin
            if (digit_out.valid) begin
               byte_in  = {DIGIT_HIGH_NIBBLE, digit_out.value};
               last_in  = digit_out.last;
               state_in = SEQ_HI;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready   = (state_ff == SEQ_IDLE);
      digit_cmd.start = (state_ff == SEQ_IDLE) && req_bus.valid
                        && (req_bus.operation == OP_PRINT);
      digit_cmd.number = req_bus.number;
      digit_cmd.take  = (state_ff == SEQ_DIGIT);
      emit_valid      = 1'b0;
      emit_word.rs_level    = rs_ff;
      emit_word.data_nibble = byte_ff[7:4];
      emit_word.lead_us     = LEAD_NONE;
      emit_word.settle_us   = SETTLE_US;
      emit_word.last_of_run = 1'b0;
      unique case (state_ff)
         SEQ_INIT: begin
            emit_valid            = 1'b1;
            emit_word             = init_nibble(step_ff);
            emit_word.last_of_run = (step_ff == INIT_LAST_STEP);
         end
         SEQ_HI: emit_valid = 1'b1;
         SEQ_LO: begin
            emit_valid            = 1'b1;
            emit_word.data_nibble = byte_ff[3:0];
            emit_word.settle_us   = slow_cmd ? SETTLE_SLOW : SETTLE_US;
            emit_word.last_of_run = last_ff;
         end
         SEQ_IDLE, SEQ_DIGIT: emit_valid = 1'b0;
         default: emit_valid = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff  <= step_in;
      byte_ff  <= byte_in;
      rs_ff    <= rs_in;
      last_ff  <= last_in;
      print_ff <= print_in;
   end

endmodule

@@ rtl/char_lcd_4bit_write_sequencer.sv @@
// Top level of the 4-bit character LCD write sequencer: sequencer, digit
// unit and the response output register. Depends on clcd_pkg, clcd_if,
// clcd_digit_unit and clcd_sequencer.
`timescale 1ns / 1ps
//
//   Channel   Direction  Word carried
//   req_bus   in         operation, byte_value, row, column, number
//   rsp_bus   out        rs_level, data_nibble, lead_us, settle_us, last_of_run
//
// A request is taken only while the sequencer is idle, one request at a time.
// Each response word passes from the sequencer through the output register;
// a byte goes out as two words and initialization as fourteen.
// Print decimal runs a single compare/subtract unit, one step per cycle except
// while a found digit waits to be taken; up to ten steps per decimal place.
// Reset is synchronous and returns both state machines to idle with no word
// pending; a stalled rsp_bus holds its word and the sequencer waits behind it.

module char_lcd_4bit_write_sequencer (
   input  logic       clock,
   input  logic       reset,
   clcd_req_if.sink   req_bus,
   clcd_rsp_if.source rsp_bus
);
   import clcd_pkg::*;

   nib_word_type  emit_word;
   logic          emit_valid;
   logic          emit_ready;
   digit_cmd_type digit_cmd;
   digit_out_type digit_out;

   // The response register: a new word may enter when the slot is empty or
   // its current word leaves in this same cycle.
   logic          rsp_valid_ff, rsp_valid_in;
   nib_word_type  rsp_word_ff, rsp_word_in;

   clcd_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .emit_word  (emit_word),
      .emit_valid (emit_valid),
      .emit_ready (emit_ready),
      .digit_cmd  (digit_cmd),
      .digit_out  (digit_out)
   );

   clcd_digit_unit u_digit_unit (
      .clock     (clock),
      .reset     (reset),
      .digit_cmd (digit_cmd),
      .digit_out (digit_out)
   );

   assign emit_ready = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (emit_ready) begin
         rsp_valid_in = emit_valid;
         rsp_word_in  = emit_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.rs_level    = rsp_word_ff.rs_level;
   assign rsp_bus.data_nibble = rsp_word_ff.data_nibble;
   assign rsp_bus.lead_us     = rsp_word_ff.lead_us;
   assign rsp_bus.settle_us   = rsp_word_ff.settle_us;
   assign rsp_bus.last_of_run = rsp_word_ff.last_of_run;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the 4-bit character LCD write sequencer.
// It uses clcd_pkg and the clcd_req_if / clcd_rsp_if channels from the RTL.
`timescale 1ns / 1ps

module testbench;
   import clcd_pkg::*;

   // Run control. The quiet limit covers the long receiver hold-off plus the
   // longest random gap and a full five-digit print, with ample margin.
   localparam int RESET_CYCLES  = 12;
   localparam int DRAIN_CYCLES  = 120;
   localparam int QUIET_LIMIT   = 4000;
   localparam int HOLD_OFF      = 300;
   localparam int RANDOM_ITEMS  = 260;
   localparam int REPORT_LIMIT  = 40;

   // Highest operation code the request field can carry; codes above print
   // decimal are unused and must be swallowed without any word.
   localparam logic [OP_W-1:0] OP_LAST_CODE = '1;

   // Power-up nibbles and commands, as the HD44780 wants them in 4-bit mode.
   localparam logic [NIBBLE_W-1:0] WAKE_NIBBLE      = 4'h3;
   localparam logic [NIBBLE_W-1:0] FOUR_BIT_NIBBLE  = 4'h2;
   localparam logic [BYTE_W-1:0]   CMD_FUNCTION_SET = 8'h28;
   localparam logic [BYTE_W-1:0]   CMD_DISPLAY_OFF  = 8'h08;
   localparam logic [BYTE_W-1:0]   CMD_ENTRY_MODE   = 8'h06;
   localparam logic [BYTE_W-1:0]   CMD_DISPLAY_ON   = 8'h0C;

   // Cursor addressing and digit encoding.
   localparam logic [BYTE_W-1:0] DDRAM_SET  = 8'h80;
   localparam logic [BYTE_W-1:0] ROW_OFFSET = 8'h40;
   localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic [BYTE_W-1:0]   byte_value;
      logic                row;
      logic [COLUMN_W-1:0] column;
      logic [NUMBER_W-1:0] number;
   } lcd_request_type;

   logic clock = 1'b0;
   logic reset;

   clcd_req_if req_if ();
   clcd_rsp_if rsp_if ();

   char_lcd_4bit_write_sequencer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   always #4 clock = ~clock;

   // Nibble words that the bus still owes us, oldest first.
   nib_word_type bus_nibbles_due[$];

   // Idling controls shared by the sender, the receiver and the test tasks.
   bit gaps_off    = 1'b0;
   int hold_cycles = 0;

   // Bookkeeping for the summary and the verdict.
   int mismatch_count = 0;
   int words_checked  = 0;
   int ignored_seen   = 0;
   int op_seen[OP_PRINT+1];
   int quiet_cycles   = 0;

   // Most gaps are short, about one in ten is long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (gaps_off || roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic lcd_request_type make_request(
      input logic [OP_W-1:0] operation, input logic [BYTE_W-1:0] byte_value,
      input logic row, input logic [COLUMN_W-1:0] column,
      input logic [NUMBER_W-1:0] number);
      lcd_request_type r;
      r.operation  = operation;
      r.byte_value = byte_value;
      r.row        = row;
      r.column     = column;
      r.number     = number;
      return r;
   endfunction

   // A request of the given operation with every other field random.
   function automatic lcd_request_type random_fields(input logic [OP_W-1:0] operation);
      return make_request(operation, BYTE_W'($urandom), 1'($urandom),
                          COLUMN_W'($urandom), NUMBER_W'($urandom));
   endfunction

   // ------------------------------------------------------------------
   // Prediction of the nibble stream.
   // ------------------------------------------------------------------

   function automatic void queue_nibble(input logic rs, input logic [NIBBLE_W-1:0] nibble,
                                        input logic [LEAD_W-1:0] lead,
                                        input logic [SETTLE_W-1:0] settle);
      nib_word_type w;
      w.rs_level    = rs;
      w.data_nibble = nibble;
      w.lead_us     = lead;
      w.settle_us   = settle;
      w.last_of_run = 1'b0;
      bus_nibbles_due.push_back(w);
   endfunction

   // A byte goes high nibble first. Only clear and home sent as commands
   // get the long execution wait after their low nibble.
   function automatic void queue_byte(input logic rs, input logic [BYTE_W-1:0] value);
      logic [SETTLE_W-1:0] low_settle;
      low_settle = (!rs && (value == CMD_CLEAR || value == CMD_HOME)) ? SETTLE_SLOW : SETTLE_US;
      queue_nibble(rs, value[7:4], LEAD_NONE, SETTLE_US);
      queue_nibble(rs, value[3:0], LEAD_NONE, low_settle);
   endfunction

   function automatic void predict_lcd_nibbles(input lcd_request_type r);
      int           first;
      int           value;
      int           weight;
      nib_word_type tail;
      first = bus_nibbles_due.size();
      case (r.operation)
         OP_INIT: begin
            // The first wake-up nibble waits out power-up; the next three
            // each need a long settle before the controller listens again.
            queue_nibble(1'b0, WAKE_NIBBLE, LEAD_POWERUP, SETTLE_FIRST);
            queue_nibble(1'b0, WAKE_NIBBLE, LEAD_NONE, SETTLE_WAKE);
            queue_nibble(1'b0, WAKE_NIBBLE, LEAD_NONE, SETTLE_WAKE);
            queue_nibble(1'b0, FOUR_BIT_NIBBLE, LEAD_NONE, SETTLE_WAKE);
            queue_byte(1'b0, CMD_FUNCTION_SET);
            queue_byte(1'b0, CMD_DISPLAY_OFF);
            queue_byte(1'b0, CMD_CLEAR);
            queue_byte(1'b0, CMD_ENTRY_MODE);
            queue_byte(1'b0, CMD_DISPLAY_ON);
         end
         OP_COMMAND: queue_byte(1'b0, r.byte_value);
         OP_DATA:    queue_byte(1'b1, r.byte_value);
         OP_CURSOR:  queue_byte(1'b0, DDRAM_SET | ((r.row ? ROW_OFFSET : 8'h00) + r.column));
         OP_PRINT: begin
            // Find the leading place, then emit one digit per place so that
            // zero still prints as a single character.
            value  = int'(r.number);
            weight = 1;
            while (value / weight >= 10) weight = weight * 10;
            while (weight > 0) begin
               queue_byte(1'b1, BYTE_W'(ASCII_ZERO + value / weight));
               value  = value % weight;
               weight = weight / 10;
            end
         end
         default: ;
      endcase
      if (bus_nibbles_due.size() > first) begin
         tail = bus_nibbles_due.pop_back();
         tail.last_of_run = 1'b1;
         bus_nibbles_due.push_back(tail);
      end
   endfunction

   // ------------------------------------------------------------------
   // Checking.
   // ------------------------------------------------------------------

   function automatic void note_failure(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t ns: %s expected %0d actual %0d", $time, what, want, got);
      if (mismatch_count == REPORT_LIMIT)
         $display("%0t ns: further mismatches are counted but not shown", $time);
   endfunction

   function automatic void check_nibble_word();
      nib_word_type want;
      if (bus_nibbles_due.size() == 0) begin
         note_failure("unexpected word, words waiting", 0, 1);
         return;
      end
      want = bus_nibbles_due.pop_front();
      words_checked++;
      if (rsp_if.rs_level !== want.rs_level)
         note_failure("rs_level", 32'(want.rs_level), 32'(rsp_if.rs_level));
      if (rsp_if.data_nibble !== want.data_nibble)
         note_failure("data_nibble", 32'(want.data_nibble), 32'(rsp_if.data_nibble));
      if (rsp_if.lead_us !== want.lead_us)
         note_failure("lead_us", 32'(want.lead_us), 32'(rsp_if.lead_us));
      if (rsp_if.settle_us !== want.settle_us)
         note_failure("settle_us", 32'(want.settle_us), 32'(rsp_if.settle_us));
      if (rsp_if.last_of_run !== want.last_of_run)
         note_failure("last_of_run", 32'(want.last_of_run), 32'(rsp_if.last_of_run));
   endfunction

   // Both channels are watched at the rising edge. A request is predicted
   // before the response word of the same edge is checked, so the order of
   // the due list always matches the order on the bus.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            predict_lcd_nibbles(make_request(req_if.operation, req_if.byte_value,
                                             req_if.row, req_if.column, req_if.number));
            if (req_if.operation > OP_PRINT) ignored_seen++;
            else op_seen[req_if.operation]++;
         end
         if (rsp_if.valid && rsp_if.ready)
            check_nibble_word();
      end
   end

   // Watchdog: counts edges at which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t ns: watchdog expired with %0d words outstanding",
                     $time, bus_nibbles_due.size());
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Receiver. A hold-off set by a test wins over the random gaps and is
   // counted down here, once per falling edge.
   initial begin
      int gap_left;
      gap_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_if.ready = 1'b0;
            hold_cycles--;
         end else if (gap_left > 0) begin
            rsp_if.ready = 1'b0;
            gap_left--;
         end else begin
            rsp_if.ready = 1'b1;
            gap_left = pick_gap();
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------

   // Offers one request word after a random gap and returns at the edge
   // that accepts it. Valid stays high if the next word follows at once.
   task automatic send_request(input lcd_request_type r);
      int gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_if.valid = 1'b0;
      end
      @(negedge clock);
      req_if.operation  = r.operation;
      req_if.byte_value = r.byte_value;
      req_if.row        = r.row;
      req_if.column     = r.column;
      req_if.number     = r.number;
      req_if.valid      = 1'b1;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Initialization, with every unused field at its top value.
   task automatic test_power_up();
      send_request(make_request(OP_INIT, '1, 1'b1, '1, '1));
   endtask

   // Command bytes at both extremes, plus clear and home with their long wait.
   task automatic test_command_bytes();
      send_request(make_request(OP_COMMAND, 8'h00, 1'b0, '0, '0));
      send_request(make_request(OP_COMMAND, 8'hFF, 1'b1, '1, '1));
      send_request(make_request(OP_COMMAND, CMD_CLEAR, 1'b0, '0, '0));
      send_request(make_request(OP_COMMAND, CMD_HOME, 1'b0, '0, '0));
      send_request(make_request(OP_COMMAND, 8'h03, 1'b0, '0, '0));
   endtask

   // Data bytes, including the clear and home values that must not slow down.
   task automatic test_data_bytes();
      send_request(make_request(OP_DATA, 8'h00, 1'b0, '0, '0));
      send_request(make_request(OP_DATA, 8'hFF, 1'b1, '1, '1));
      send_request(make_request(OP_DATA, CMD_CLEAR, 1'b0, '0, '0));
      send_request(make_request(OP_DATA, CMD_HOME, 1'b0, '0, '0));
   endtask

   // The four corners of the display.
   task automatic test_cursor_corners();
      send_request(make_request(OP_CURSOR, '0, 1'b0, 4'd0, '0));
      send_request(make_request(OP_CURSOR, '1, 1'b0, 4'd15, '1));
      send_request(make_request(OP_CURSOR, '0, 1'b1, 4'd0, '0));
      send_request(make_request(OP_CURSOR, '1, 1'b1, 4'd15, '1));
   endtask

   // Zero, digit-count boundaries and the largest value.
   task automatic test_print_boundaries();
      send_request(make_request(OP_PRINT, '0, 1'b0, '0, 16'd0));
      send_request(make_request(OP_PRINT, '0, 1'b0, '0, 16'd9));
      send_request(make_request(OP_PRINT, '0, 1'b0, '0, 16'd10));
      send_request(make_request(OP_PRINT, '0, 1'b0, '0, 16'd99));
      send_request(make_request(OP_PRINT, '0, 1'b0, '0, 16'd100));
      send_request(make_request(OP_PRINT, '0, 1'b0, '0, 16'd10000));
      send_request(make_request(OP_PRINT, '1, 1'b1, '1, 16'd65535));
   endtask

   // Unused operation codes produce nothing.
   task automatic test_unused_codes();
      for (int code = OP_PRINT + 1; code <= OP_LAST_CODE; code++)
         send_request(make_request(OP_W'(code), '1, 1'b1, '1, '1));
   endtask

   // The receiver stops for a long stretch while the sender keeps offering
   // long requests back to back, so the output register fills and the
   // sequencer has to refuse new requests until the stall ends.
   task automatic test_output_stall();
      lcd_request_type r;
      gaps_off    = 1'b1;
      hold_cycles = HOLD_OFF;
      send_request(random_fields(OP_INIT));
      r = random_fields(OP_PRINT);
      r.number = 16'd54321;
      send_request(r);
      send_request(make_request(OP_COMMAND, CMD_CLEAR, 1'b0, '0, '0));
      r = random_fields(OP_PRINT);
      r.number = 16'd60000;
      send_request(r);
      send_request(random_fields(OP_DATA));
      gaps_off = 1'b0;
   endtask

   function automatic lcd_request_type random_request();
      lcd_request_type r;
      int              roll;
      int              digits;
      r    = random_fields('0);
      roll = $urandom_range(0, 99);
      if (roll < 5)       r.operation = OP_INIT;
      else if (roll < 25) r.operation = OP_COMMAND;
      else if (roll < 48) r.operation = OP_DATA;
      else if (roll < 63) r.operation = OP_CURSOR;
      else if (roll < 92) r.operation = OP_PRINT;
      else                r.operation = OP_W'($urandom_range(OP_PRINT + 1, OP_LAST_CODE));
      // Clear and home deserve more than their random share.
      if (r.operation == OP_COMMAND && $urandom_range(0, 9) == 0)
         r.byte_value = $urandom_range(0, 1) ? CMD_CLEAR : CMD_HOME;
      // Spread print values over every digit count, not just five digits.
      if (r.operation == OP_PRINT) begin
         digits = $urandom_range(1, 5);
         case (digits)
            1:       r.number = NUMBER_W'($urandom_range(0, 9));
            2:       r.number = NUMBER_W'($urandom_range(10, 99));
            3:       r.number = NUMBER_W'($urandom_range(100, 999));
            4:       r.number = NUMBER_W'($urandom_range(1000, 9999));
            default: r.number = NUMBER_W'($urandom_range(10000, 65535));
         endcase
      end
      return r;
   endfunction

   // Random traffic, with one stretch where neither side idles.
   task automatic test_random_traffic();
      lcd_request_type r;
      int              useful;
      useful = 0;
      while (useful < RANDOM_ITEMS) begin
         gaps_off = (useful >= 120 && useful < 170);
         r = random_request();
         send_request(r);
         if (r.operation <= OP_PRINT) useful++;
      end
      gaps_off = 1'b0;
   endtask

   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.operation  = '0;
      req_if.byte_value = '0;
      req_if.row        = 1'b0;
      req_if.column     = '0;
      req_if.number     = '0;
      foreach (op_seen[i]) op_seen[i] = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_power_up();
      test_command_bytes();
      test_data_bytes();
      test_cursor_corners();
      test_print_boundaries();
      test_unused_codes();
      test_output_stall();
      test_random_traffic();

      @(negedge clock);
      req_if.valid = 1'b0;

      // Wait for the last owed word, then give the block time to show any
      // stray word it should not produce.
      while (bus_nibbles_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Requests: %0d init, %0d command, %0d data, %0d cursor, %0d print, %0d unused",
               op_seen[OP_INIT], op_seen[OP_COMMAND], op_seen[OP_DATA],
               op_seen[OP_CURSOR], op_seen[OP_PRINT], ignored_seen);
      $display("Nibble words checked: %0d, mismatches: %0d", words_checked, mismatch_count);
      if (mismatch_count == 0 && bus_nibbles_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
